// ===== sv/fpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fit-policy free-list allocator.
// No dependencies; imported by fpa_cell and fit_policy_free_list_allocator.
package fpa_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS   = 16;
	localparam int AMT_W       = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// request opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_BEST   = 2'd1;
	localparam logic [1:0] OP_FIRST  = 2'd2;
	localparam logic [1:0] OP_WORST  = 2'd3;

	// response status codes
	localparam logic [1:0] ST_ALLOC    = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_INSERTED = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// table update commands broadcast to every cell
	localparam logic [1:0] CMD_HOLD  = 2'd0;
	localparam logic [1:0] CMD_PUSH  = 2'd1;
	localparam logic [1:0] CMD_PULL  = 2'd2;
	localparam logic [1:0] CMD_CARVE = 2'd3;

	// one free-region entry
	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] base;
		logic [AMT_W-1:0]     len;
	} entry_t;

	// best-so-far candidate carried along the chain
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     pick;
		logic [ADDR_BITS-1:0] pbase;
		logic [AMT_W-1:0]     plen;
	} tok_t;

	// search policy and request size, broadcast during a scan
	typedef struct packed {
		logic [1:0]       policy;
		logic [AMT_W-1:0] amount;
	} search_t;

	// table update command
	typedef struct packed {
		logic [1:0]       code;
		logic [IDX_W-1:0] pick;
		logic [AMT_W-1:0] amount;
	} cmd_t;

endpackage

// ===== sv/fpa_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds a free region and evaluates the search word passing through.
// Depends on fpa_pkg.
module fpa_cell
	import fpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  search_t          srch,
	input  cmd_t             cmd,
	input  entry_t           left_ent,
	input  entry_t           right_ent,
	input  logic             left_tok_vld,
	input  tok_t             left_tok,
	output entry_t           ent,
	output logic             tok_vld,
	output tok_t             tok
);

	entry_t ent_q;
	logic   tok_vld_q;
	tok_t   tok_q;
	logic   fits;
	logic   better;
	logic   take;
	tok_t   tok_next;

	assign ent     = ent_q;
	assign tok_vld = tok_vld_q;
	assign tok     = tok_q;

	// candidate compare against the word coming from the left
	always_comb begin
		fits   = ent_q.valid && (ent_q.len >= srch.amount);
		better = ((srch.policy == OP_BEST) && (ent_q.len < left_tok.plen)) ||
			((srch.policy == OP_WORST) && (ent_q.len > left_tok.plen));
		take   = fits && (!left_tok.found || better);
		tok_next = left_tok;
		if (take) begin
			tok_next.found = 1'b1;
			tok_next.pick  = idx;
			tok_next.pbase = ent_q.base;
			tok_next.plen  = ent_q.len;
		end
	end

	// search word register, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= left_tok_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (left_tok_vld) begin
			tok_q <= tok_next;
		end
	end

	// entry update: shift toward tail, shift toward head, or carve in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			unique case (cmd.code)
				CMD_HOLD: begin
					ent_q <= ent_q;
				end
				CMD_PUSH: begin
					ent_q <= left_ent;
				end
				CMD_PULL: begin
					if (idx >= cmd.pick) begin
						ent_q <= right_ent;
					end
				end
				CMD_CARVE: begin
					if (idx == cmd.pick) begin
						ent_q.len  <= ent_q.len - cmd.amount;
						ent_q.base <= ent_q.base + ADDR_BITS'(cmd.amount);
					end
				end
				default: begin
					ent_q <= ent_q;
				end
			endcase
		end
	end

endmodule

// ===== sv/fit_policy_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Fit-policy free-list allocator top level: controller, cell chain, response register.
// Depends on fpa_pkg and fpa_cell.
//
// Keeps up to TABLE_DEPTH free regions in a row of cells, head at cell 0. On an insert
// the whole row shifts one cell toward the tail at once. An allocation (best, first or
// worst fit) goes through these steps: the search word is launched, walks the row one
// cell per clock, always through every cell, the result is taken from the tail, and
// the update (carve in place or shift toward the head) is applied. The response
// sits in an output register, so a new request is taken while an earlier response is
// still stalled; a finished request waits in its last step only if that register is full.
module fit_policy_free_list_allocator
	import fpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           opcode,
	input  logic [ADDR_BITS-1:0] region_start,
	input  logic [AMT_W-1:0]     amount,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] granted_start
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic [1:0]           op_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [AMT_W-1:0]     amount_q;
	logic                 launch_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_vld_q;
	logic [1:0]           status_q;
	logic [ADDR_BITS-1:0] granted_q;

	logic    req_acc;
	logic    out_free;
	logic    finish;
	search_t srch;
	cmd_t    cmd;
	entry_t  new_ent;
	tok_t    tail_tok;
	logic    tail_vld;
	logic [1:0]           fin_status;
	logic [ADDR_BITS-1:0] fin_granted;
	logic [CNT_W-1:0]     fin_count;

	entry_t ent     [TABLE_DEPTH];
	logic   tok_vld [TABLE_DEPTH];
	tok_t   tok     [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_vec;

	assign req_stall     = (state_q != S_IDLE);
	assign req_acc       = req_valid && !req_stall;
	assign out_free      = !out_vld_q || !rsp_stall;
	assign finish        = (state_q == S_FIN) && out_free;
	assign rsp_valid     = out_vld_q;
	assign status        = status_q;
	assign granted_start = granted_q;

	assign srch.policy = op_q;
	assign srch.amount = amount_q;

	assign new_ent.valid = 1'b1;
	assign new_ent.base  = start_q;
	assign new_ent.len   = amount_q;

	assign tail_tok = tok[TABLE_DEPTH-1];
	assign tail_vld = tok_vld[TABLE_DEPTH-1];

	// cell chain
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t l_ent;
		entry_t r_ent;
		logic   l_vld;
		tok_t   l_tok;

		if (i == 0) begin : g_head
			assign l_ent = new_ent;
			assign l_vld = launch_q;
			assign l_tok = '0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_vld = tok_vld[i-1];
			assign l_tok = tok[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign r_ent = '0;
		end else begin : g_body
			assign r_ent = ent[i+1];
		end

		assign valid_vec[i] = ent[i].valid;

		fpa_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.idx          (IDX_W'(i)),
			.srch         (srch),
			.cmd          (cmd),
			.left_ent     (l_ent),
			.right_ent    (r_ent),
			.left_tok_vld (l_vld),
			.left_tok     (l_tok),
			.ent          (ent[i]),
			.tok_vld      (tok_vld[i]),
			.tok          (tok[i])
		);
	end

	// final decision: table command, response and new count
	always_comb begin
		cmd.code    = CMD_HOLD;
		cmd.pick    = tail_tok.pick;
		cmd.amount  = amount_q;
		fin_status  = ST_NOFIT;
		fin_granted = '0;
		fin_count   = count_q;
		if (op_q == OP_INSERT) begin
			if (count_q == CNT_W'(TABLE_DEPTH)) begin
				fin_status = ST_FULL;
			end else begin
				fin_status = ST_INSERTED;
				if (finish) begin
					cmd.code = CMD_PUSH;
				end
				fin_count = count_q + CNT_W'(1);
			end
		end else if (tail_tok.found) begin
			fin_status  = ST_ALLOC;
			fin_granted = tail_tok.pbase;
			if (tail_tok.plen == amount_q) begin
				if (finish) begin
					cmd.code = CMD_PULL;
				end
				fin_count = count_q - CNT_W'(1);
			end else if (finish) begin
				cmd.code = CMD_CARVE;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= opcode;
			start_q  <= region_start;
			amount_q <= amount;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			count_q  <= '0;
		end else begin
			launch_q <= req_acc && (opcode != OP_INSERT);
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= (opcode == OP_INSERT) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail_vld) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						count_q <= fin_count;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q  <= fin_status;
			granted_q <= fin_granted;
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("region count above table depth");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with region count");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |-> (state_q == S_SCAN))
		else $error("search word left the chain outside a scan");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (state_q == S_IDLE) && out_vld_q)
		else $error("finished request did not load the response");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && (op_q == OP_INSERT) && (count_q == CNT_W'(TABLE_DEPTH)))
		|=> (status_q == ST_FULL) && (count_q == $past(count_q)))
		else $error("insert into full table not dropped");

endmodule
